// ----- hw/rtl/bli_pkg.sv -----
// Package for the breakpoint linear interpolator.
// Holds operation codes and register addresses shared by the RTL files.
package bli_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int  APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] REG_LEVEL_COUNT = 2'd0;

  localparam int  LEVEL_COUNT_W = 5;
  localparam logic [LEVEL_COUNT_W-1:0] LEVEL_COUNT_RESET = 5'd2;

  localparam int SEG_W = 4;

endpackage

// ----- hw/rtl/bli_div_pipe.sv -----
// Pipelined restoring divider for the interpolator, STEP quotient bits per stage.
// Carries an opaque sideband vector alongside each request. Uses bli_pkg.
module bli_div_pipe #(
  parameter int QB   = 33,
  parameter int DB   = 33,
  parameter int SW   = 8,
  parameter int STEP = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [QB+DB-1:0] dividend_i,
  input  logic [DB-1:0]    divisor_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QB-1:0]    quot_o,
  output logic [SW-1:0]    side_o
);
  import bli_pkg::*;

  localparam int NS = (QB + STEP - 1) / STEP;

  logic          v_q    [NS];
  logic [DB-1:0] r_q    [NS];
  logic [QB-1:0] a_q    [NS];
  logic [DB-1:0] d_q    [NS];
  logic [SW-1:0] side_q [NS];

  logic [DB-1:0] r_d [NS];
  logic [QB-1:0] a_d [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DB-1:0] r_in;
    logic [QB-1:0] a_in;
    logic [DB-1:0] d_in;
    logic          v_in;
    logic [SW-1:0] side_in;

    if (k == 0) begin : g_first
      // remainder starts with the top bits; quotient fits in QB bits
      assign r_in    = dividend_i[QB+DB-1:QB];
      assign a_in    = dividend_i[QB-1:0];
      assign d_in    = divisor_i;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign r_in    = r_q[k-1];
      assign a_in    = a_q[k-1];
      assign d_in    = d_q[k-1];
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      logic [DB:0]   t;
      logic [DB-1:0] r;
      logic [QB-1:0] a;
      r = r_in;
      a = a_in;
      for (int j = 0; j < STEP; j++) begin
        if (k * STEP + j < QB) begin
          t = {r, a[QB-1]};
          a = {a[QB-2:0], 1'b0};
          if (t >= {1'b0, d_in}) begin
            t    = t - {1'b0, d_in};
            a[0] = 1'b1;
          end
          r = t[DB-1:0];
        end
      end
      r_d[k] = r;
      a_d[k] = a;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= r_d[k];
        a_q[k]    <= a_d[k];
        d_q[k]    <= d_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign quot_o  = a_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

// ----- hw/rtl/breakpoint_linear_interpolator.sv -----
// Breakpoint linear interpolator: table of pressure/wind breakpoints and a
// fully pipelined interpolation datapath. Uses bli_pkg and bli_div_pipe.
//
// Usage:
//   Input channel (valid_i/stall_o) carries load and query requests. A load
//   writes one breakpoint at the accept edge and returns nothing; a query
//   returns one result on the output channel (valid_o/stall_i).
//   The APB port holds level_count at address 0; write it only while idle.
// Throughput and pipeline:
//   One request per cycle while the pipe is not stalled. A query result passes
//   through the segment search, difference stage, multiply stage, the divider
//   stages (four quotient bits each) and the output register, the first loading
//   at the accept edge.
// Reset:
//   Clears all valid bits and sets level_count to 2. Table entries hold
//   nothing defined until loaded.
// Stall:
//   When a result waits with stall_i high the whole pipe holds and stall_o
//   rises; nothing is lost or repeated.
module breakpoint_linear_interpolator #(
  parameter int MAX_LEVELS    = 16,
  parameter int PRESSURE_BITS = 32,
  parameter int WIND_BITS     = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic                                operation_i,
  input  logic [3:0]                          entry_index_i,
  input  logic signed [PRESSURE_BITS-1:0]     entry_pressure_i,
  input  logic signed [WIND_BITS-1:0]         entry_wind_i,
  input  logic signed [PRESSURE_BITS-1:0]     query_pressure_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [WIND_BITS-1:0]         wind_value_o,
  output logic                                in_range_o,
  output logic [3:0]                          segment_index_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bli_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import bli_pkg::*;

  localparam int P  = PRESSURE_BITS;
  localparam int W  = WIND_BITS;
  localparam int QB = W + 1;
  localparam int DB = P + 1;
  localparam int SW = W + SEG_W + 3;

  logic en;
  logic out_valid_q;

  assign en      = !(out_valid_q && stall_i);
  assign stall_o = !en;

  // configuration
  logic [LEVEL_COUNT_W-1:0] level_count_q;
  assign pready = 1'b1;
  assign prdata = {{(32-LEVEL_COUNT_W){1'b0}}, level_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= LEVEL_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_LEVEL_COUNT) begin
      level_count_q <= pwdata[LEVEL_COUNT_W-1:0];
    end
  end

  // breakpoint table
  logic signed [P-1:0] pres_q [MAX_LEVELS];
  logic signed [W-1:0] wind_q [MAX_LEVELS];
  logic accept;

  assign accept = valid_i && en;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (accept && operation_i == OP_LOAD && int'(entry_index_i) == i) begin
        pres_q[i] <= entry_pressure_i;
        wind_q[i] <= entry_wind_i;
      end
    end
  end

  // stage 1: segment search
  int lv;
  logic                found_d;
  logic [SEG_W-1:0]    seg_d;
  logic signed [P-1:0] p0_d, p1_d;
  logic signed [W-1:0] u0_d, u1_d;

  always_comb begin
    logic signed [P-1:0] lo, hi;
    lv = int'(level_count_q);
    if (lv < 2) lv = 2;
    if (lv > MAX_LEVELS) lv = MAX_LEVELS;
    found_d = 1'b0;
    seg_d   = '0;
    p0_d    = pres_q[0];
    p1_d    = pres_q[1];
    u0_d    = wind_q[0];
    u1_d    = wind_q[1];
    // walk downward so the lowest bracketing segment wins
    for (int i = MAX_LEVELS - 2; i >= 0; i--) begin
      lo = (pres_q[i] < pres_q[i+1]) ? pres_q[i] : pres_q[i+1];
      hi = (pres_q[i] < pres_q[i+1]) ? pres_q[i+1] : pres_q[i];
      if (i + 1 < lv && query_pressure_i >= lo && query_pressure_i <= hi) begin
        found_d = 1'b1;
        seg_d   = SEG_W'(i);
        p0_d    = pres_q[i];
        p1_d    = pres_q[i+1];
        u0_d    = wind_q[i];
        u1_d    = wind_q[i+1];
      end
    end
  end

  logic                s1_valid_q, s1_found_q;
  logic [SEG_W-1:0]    s1_seg_q;
  logic signed [P-1:0] s1_p_q, s1_p0_q, s1_p1_q;
  logic signed [W-1:0] s1_u0_q, s1_u1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= valid_i && operation_i == OP_QUERY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_found_q <= found_d;
      s1_seg_q   <= seg_d;
      s1_p_q     <= query_pressure_i;
      s1_p0_q    <= p0_d;
      s1_p1_q    <= p1_d;
      s1_u0_q    <= u0_d;
      s1_u1_q    <= u1_d;
    end
  end

  // stage 2: differences and magnitudes
  logic signed [W:0]   du;
  logic signed [P:0]   dp, dx;
  logic [QB-1:0]       mdu_d;
  logic [DB-1:0]       mdp_d, mdx_d;

  assign du    = {s1_u1_q[W-1], s1_u1_q} - {s1_u0_q[W-1], s1_u0_q};
  assign dp    = {s1_p1_q[P-1], s1_p1_q} - {s1_p0_q[P-1], s1_p0_q};
  assign dx    = {s1_p_q[P-1], s1_p_q} - {s1_p0_q[P-1], s1_p0_q};
  assign mdu_d = du[W] ? QB'(-du) : QB'(du);
  assign mdp_d = dp[P] ? DB'(-dp) : DB'(dp);
  assign mdx_d = dx[P] ? DB'(-dx) : DB'(dx);

  logic                s2_valid_q, s2_found_q, s2_neg_q, s2_flat_q;
  logic [SEG_W-1:0]    s2_seg_q;
  logic signed [W-1:0] s2_u0_q;
  logic [QB-1:0]       s2_mdu_q;
  logic [DB-1:0]       s2_mdp_q, s2_mdx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_found_q <= s1_found_q;
      s2_seg_q   <= s1_seg_q;
      s2_u0_q    <= s1_u0_q;
      s2_neg_q   <= du[W] ^ dp[P] ^ dx[P];
      // flat segment or exact lower breakpoint: result is U0
      s2_flat_q  <= (s1_p0_q == s1_p1_q) || (s1_p_q == s1_p0_q);
      s2_mdu_q   <= mdu_d;
      // keep the divisor nonzero so the divider stays well defined
      s2_mdp_q   <= (mdp_d == '0) ? DB'(1) : mdp_d;
      s2_mdx_q   <= mdx_d;
    end
  end

  // stage 3: product
  logic                s3_valid_q;
  logic [QB+DB-1:0]    s3_prod_q;
  logic [DB-1:0]       s3_mdp_q;
  logic [SW-1:0]       s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_prod_q <= (QB+DB)'(s2_mdu_q) * (QB+DB)'(s2_mdx_q);
      s3_mdp_q  <= s2_mdp_q;
      s3_side_q <= {s2_found_q, s2_neg_q, s2_flat_q, s2_seg_q, s2_u0_q};
    end
  end

  // divider stages
  logic          dv_valid;
  logic [QB-1:0] dv_quot;
  logic [SW-1:0] dv_side;

  bli_div_pipe #(
    .QB   (QB),
    .DB   (DB),
    .SW   (SW),
    .STEP (4)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s3_valid_q),
    .dividend_i (s3_prod_q),
    .divisor_i  (s3_mdp_q),
    .side_i     (s3_side_q),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  // output stage: apply sign and offset; zero when no segment is found
  logic                dv_found, dv_neg, dv_flat;
  logic [SEG_W-1:0]    dv_seg;
  logic signed [W-1:0] dv_u0;
  logic [W-1:0]        res_d;

  assign {dv_found, dv_neg, dv_flat, dv_seg, dv_u0} = dv_side;

  always_comb begin
    if (!dv_found) begin
      res_d = '0;
    end else if (dv_flat) begin
      res_d = dv_u0;
    end else if (dv_neg) begin
      res_d = dv_u0 - dv_quot[W-1:0];
    end else begin
      res_d = dv_u0 + dv_quot[W-1:0];
    end
  end

  logic [W-1:0]     out_wind_q;
  logic             out_found_q;
  logic [SEG_W-1:0] out_seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_wind_q  <= res_d;
      out_found_q <= dv_found;
      out_seg_q   <= dv_found ? dv_seg : '0;
    end
  end

  assign valid_o         = out_valid_q;
  assign wind_value_o    = out_wind_q;
  assign in_range_o      = out_found_q;
  assign segment_index_o = out_seg_q;

endmodule
